/* rtl/bertlv_pkg.sv */
// ----------------------------------------------------------------------------
// BER TLV stream decoder package
// Types, result codes and tag constants shared by the decoder RTL.
// ----------------------------------------------------------------------------
package bertlv_pkg;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_LENX,
    PH_BODY,
    PH_SKIP
  } phase_t;

  // Kind of a result item.
  typedef enum logic [2:0] {
    K_INT   = 3'd0,
    K_UNS   = 3'd1,
    K_OID   = 3'd2,
    K_STR   = 3'd3,
    K_EMPTY = 3'd4,
    K_HDR   = 3'd5,
    K_ERR   = 3'd6
  } kind_t;

  // Error codes carried by an error result.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RSVD_LEN = 3'd1,
    ERR_LONG_LEN = 3'd2,
    ERR_TRUNC    = 3'd3,
    ERR_TOO_LONG = 3'd4,
    ERR_IP_LEN   = 3'd5,
    ERR_UNK_TAG  = 3'd6,
    ERR_OID_CUT  = 3'd7
  } err_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [32:0] value;
    err_t        err;
    logic        eoe;
  } res_t;

  // SNMP tag codes.
  localparam logic [7:0] TAG_INT      = 8'h02;
  localparam logic [7:0] TAG_OCTSTR   = 8'h04;
  localparam logic [7:0] TAG_NULL     = 8'h05;
  localparam logic [7:0] TAG_OID      = 8'h06;
  localparam logic [7:0] TAG_IPADDR   = 8'h40;
  localparam logic [7:0] TAG_COUNTER  = 8'h41;
  localparam logic [7:0] TAG_GAUGE    = 8'h42;
  localparam logic [7:0] TAG_TICKS    = 8'h43;
  localparam logic [7:0] TAG_OPAQUE   = 8'h44;
  localparam logic [7:0] TAG_NOOBJ    = 8'h80;
  localparam logic [7:0] TAG_NOINST   = 8'h81;
  localparam logic [7:0] TAG_ENDVIEW  = 8'h82;

  // Length byte that is reserved and rejected.
  localparam logic [7:0] LEN_RESERVED = 8'hff;

  // Result queue depth.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  // Reciprocal of 40 for an 8-bit dividend: q = (b * 205) >> 13.
  localparam logic [15:0] RECIP40  = 16'd205;
  localparam logic [7:0]  OID_DIV  = 8'd40;

  function automatic logic is_null_tag(input logic [7:0] t);
    return (t == TAG_NULL) || (t == TAG_NOOBJ) || (t == TAG_NOINST) || (t == TAG_ENDVIEW);
  endfunction

  function automatic logic is_num_tag(input logic [7:0] t);
    return (t == TAG_INT) || (t == TAG_IPADDR) || (t == TAG_COUNTER) ||
           (t == TAG_GAUGE) || (t == TAG_TICKS);
  endfunction

  function automatic logic is_str_tag(input logic [7:0] t);
    return (t == TAG_OCTSTR) || (t == TAG_OPAQUE);
  endfunction

endpackage

/* rtl/ber_tlv_stream_decoder.sv */
// ----------------------------------------------------------------------------
// BER TLV stream decoder
// Parses an SNMP BER byte stream into integer, unsigned, OID subidentifier,
// string byte, empty marker, constructed header and error items.
// ----------------------------------------------------------------------------
//  Channel  Direction  Item                  Fields
//  in_      slave      one stream byte       tdata: byte_value; tlast: last_byte
//  out_     master     one decoded result    tuser: kind; tlast: end_of_element;
//                                            tdata: tag, value, error_code
//
//  Each byte is decoded between the input register and a four-entry result
//  queue, so one byte is taken per cycle while the queue has room. The first
//  byte of an OID yields two items, which the queue absorbs; the input stalls
//  only while fewer than two queue entries are free. Reset (rst_n low,
//  synchronous) returns the parser to the tag phase and empties the queue. A
//  stalled output holds its item until out_tready is seen.
// ----------------------------------------------------------------------------
module ber_tlv_stream_decoder #(
  parameter int unsigned MAX_LENGTH_BYTES = 4,
  parameter int unsigned SUBID_WIDTH      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // last_byte
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] tag, [40:8] value, [43:41] error_code, [47:44] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // end_of_element
);
  import bertlv_pkg::*;

  localparam int unsigned LenCntW = 3;

  // Input register.
  logic                     inq_valid_r;
  logic [7:0]               inq_byte_r;
  logic                     inq_last_r;

  // Parser state.
  phase_t                   phase_r, phase_nxt;
  logic [7:0]               tag_r, tag_nxt;
  logic [31:0]              rem_r, rem_nxt;
  logic [LenCntW-1:0]       lenleft_r, lenleft_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [SUBID_WIDTH-1:0]   subid_r, subid_nxt;
  logic                     first_r, first_nxt;

  // Result queue.
  res_t                     rq_r [RQ_DEPTH];
  logic [RQ_AW-1:0]         rq_wr_r, rq_rd_r;
  logic [RQ_AW:0]           rq_cnt_r;

  // Shared decode signals.
  logic [7:0]               b;
  logic                     last;
  logic                     fire;
  logic                     pop;
  logic [6:0]               bl;
  logic                     begin_now;
  logic [31:0]              len_c;
  err_t                     beg_err;
  err_t                     err_c;
  logic [31:0]              rem_dec;
  logic                     body_done;
  logic [31:0]              acc_new;
  logic [SUBID_WIDTH-1:0]   subid_shift;
  logic [SUBID_WIDTH-1:0]   subid_val;
  logic [15:0]              div_prod;
  logic [2:0]               oid_q;
  logic [7:0]               oid_r;
  logic [7:0]               tag_cur;
  logic                     t_null, t_num, t_str, t_oid, t_int;
  phase_t                   phase_beg;

  // Results of this cycle.
  logic [1:0]               nres;
  res_t                     res0, res1;

  assign b    = inq_byte_r;
  assign last = inq_last_r;
  assign bl   = b[6:0];

  // Handshakes: the queue must have room for two items before a byte is decoded.
  assign fire      = inq_valid_r && (rq_cnt_r <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign in_tready = !inq_valid_r || fire;
  assign pop       = out_tvalid && out_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      inq_byte_r <= in_tdata;
      inq_last_r <= in_tlast;
    end
  end

  // Tag classes of the element being decoded.
  assign t_null = is_null_tag(tag_r);
  assign t_num  = is_num_tag(tag_r);
  assign t_str  = is_str_tag(tag_r);
  assign t_oid  = (tag_r == TAG_OID);
  assign t_int  = (tag_r == TAG_INT);

  // Length completion and the checks made when an element begins.
  always_comb begin
    begin_now = 1'b0;
    len_c     = 32'd0;
    if (phase_r == PH_LEN) begin
      len_c     = b[7] ? 32'd0 : {24'd0, b};
      begin_now = (b != LEN_RESERVED) && (!b[7] || (bl == 7'd0));
    end else if (phase_r == PH_LENX) begin
      len_c     = {rem_r[23:0], b};
      begin_now = (lenleft_r == LenCntW'(1));
    end

    beg_err = ERR_NONE;
    if ((len_c != 32'd0) && last) begin
      beg_err = ERR_TRUNC;
    end else if (t_null) begin
      beg_err = ERR_NONE;
    end else if (t_num) begin
      if ((tag_r == TAG_IPADDR) && (len_c != 32'd4)) begin
        beg_err = ERR_IP_LEN;
      end else if (len_c > 32'd4) begin
        beg_err = ERR_TOO_LONG;
      end
    end else if (t_str || t_oid || tag_r[5]) begin
      beg_err = ERR_NONE;
    end else begin
      beg_err = ERR_UNK_TAG;
    end

    if ((len_c == 32'd0) || !(t_null || t_num || t_str || t_oid)) begin
      phase_beg = PH_TAG;
    end else if (t_null) begin
      phase_beg = PH_SKIP;
    end else begin
      phase_beg = PH_BODY;
    end
  end

  // Contents arithmetic.
  assign rem_dec     = rem_r - {31'd0, (rem_r != 32'd0)};
  assign body_done   = (rem_dec == 32'd0);
  assign acc_new     = (t_int && first_r) ? {{24{b[7]}}, b} : {acc_r[23:0], b};
  assign subid_shift = (subid_r | SUBID_WIDTH'(bl)) << 7;
  assign subid_val   = subid_r | SUBID_WIDTH'(b);
  assign div_prod    = 16'(b) * RECIP40;
  assign oid_q       = div_prod[15:13];
  assign oid_r       = b - (8'(oid_q) * OID_DIV);
  assign tag_cur     = (phase_r == PH_TAG) ? b : tag_r;

  // Error detection for the current byte.
  always_comb begin
    err_c = ERR_NONE;
    unique case (phase_r)
      PH_TAG: begin
        if (last) err_c = ERR_TRUNC;
      end
      PH_LEN: begin
        if (b == LEN_RESERVED) begin
          err_c = ERR_RSVD_LEN;
        end else if (b[7] && (bl > 7'(MAX_LENGTH_BYTES))) begin
          err_c = ERR_LONG_LEN;
        end else if (begin_now) begin
          err_c = beg_err;
        end else if (last) begin
          err_c = ERR_TRUNC;
        end
      end
      PH_LENX: begin
        if (begin_now) begin
          err_c = beg_err;
        end else if (last) begin
          err_c = ERR_TRUNC;
        end
      end
      PH_BODY: begin
        if (rem_r != 32'd0) begin
          if (!body_done && last) begin
            err_c = ERR_TRUNC;
          end else if (t_oid && !first_r && b[7] && body_done && !t_str) begin
            err_c = ERR_OID_CUT;
          end
        end
      end
      PH_SKIP: begin
        if ((rem_dec != 32'd0) && last) err_c = ERR_TRUNC;
      end
      default: err_c = ERR_NONE;
    endcase
  end

  // Next parser state.
  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    rem_nxt     = rem_r;
    lenleft_nxt = lenleft_r;
    acc_nxt     = acc_r;
    subid_nxt   = subid_r;
    first_nxt   = first_r;

    unique case (phase_r)
      PH_TAG: begin
        tag_nxt   = b;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        rem_nxt = len_c;
        if (!begin_now) begin
          lenleft_nxt = LenCntW'(bl);
          phase_nxt   = PH_LENX;
        end
      end
      PH_LENX: begin
        rem_nxt     = len_c;
        lenleft_nxt = lenleft_r - LenCntW'(1);
      end
      PH_BODY: begin
        rem_nxt = rem_dec;
        if (rem_r != 32'd0 && !body_done) begin
          if (t_str) begin
            // String bytes need no state.
          end else if (t_oid) begin
            if (first_r) begin
              first_nxt = 1'b0;
            end else if (b[7]) begin
              subid_nxt = subid_shift;
            end else begin
              subid_nxt = '0;
            end
          end else begin
            acc_nxt   = acc_new;
            first_nxt = first_r & !t_int;
          end
        end
      end
      PH_SKIP: begin
        rem_nxt = rem_dec;
      end
      default: phase_nxt = PH_TAG;
    endcase

    // An element begins once its length is complete.
    if (begin_now) begin
      acc_nxt   = '0;
      subid_nxt = '0;
      first_nxt = 1'b1;
      phase_nxt = phase_beg;
    end

    // End of contents, an error or an unknown phase clears the working state.
    if ((err_c != ERR_NONE) ||
        ((phase_r == PH_BODY) && ((rem_r == 32'd0) || body_done)) ||
        ((phase_r == PH_SKIP) && (rem_dec == 32'd0)) ||
        !((phase_r == PH_TAG) || (phase_r == PH_LEN) || (phase_r == PH_LENX) ||
          (phase_r == PH_BODY) || (phase_r == PH_SKIP))) begin
      phase_nxt   = PH_TAG;
      rem_nxt     = '0;
      lenleft_nxt = '0;
      acc_nxt     = '0;
      subid_nxt   = '0;
      first_nxt   = 1'b1;
    end
  end

  // Result items of the current byte.
  always_comb begin
    nres       = 2'd0;
    res0.kind  = K_EMPTY;
    res0.tag   = tag_cur;
    res0.value = '0;
    res0.err   = ERR_NONE;
    res0.eoe   = 1'b1;
    res1       = res0;

    if (err_c != ERR_NONE) begin
      nres      = 2'd1;
      res0.kind = K_ERR;
      res0.err  = err_c;
    end else if (begin_now) begin
      if (t_null) begin
        nres = 2'd1;
      end else if (t_num || t_str || t_oid) begin
        if (len_c == 32'd0) begin
          nres = 2'd1;
          if (t_num) res0.kind = t_int ? K_INT : K_UNS;
        end
      end else begin
        nres       = 2'd1;
        res0.kind  = K_HDR;
        res0.value = {1'b0, len_c};
        res0.eoe   = (len_c == 32'd0);
      end
    end else if ((phase_r == PH_BODY) && (rem_r != 32'd0)) begin
      res0.eoe = body_done;
      if (t_str) begin
        nres       = 2'd1;
        res0.kind  = K_STR;
        res0.value = {25'd0, b};
      end else if (t_oid) begin
        res0.kind = K_OID;
        if (first_r) begin
          nres       = 2'd2;
          res0.value = {30'd0, oid_q};
          res0.eoe   = 1'b0;
          res1.kind  = K_OID;
          res1.value = {25'd0, oid_r};
          res1.eoe   = body_done;
        end else if (!b[7]) begin
          nres       = 2'd1;
          res0.value = 33'(subid_val);
        end
      end else if (body_done) begin
        nres = 2'd1;
        if (t_int) begin
          res0.kind  = K_INT;
          res0.value = {acc_new[31], acc_new};
        end else begin
          res0.kind  = K_UNS;
          res0.value = {1'b0, acc_new};
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      tag_r     <= '0;
      rem_r     <= '0;
      lenleft_r <= '0;
      acc_r     <= '0;
      subid_r   <= '0;
      first_r   <= 1'b1;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      tag_r     <= tag_nxt;
      rem_r     <= rem_nxt;
      lenleft_r <= lenleft_nxt;
      acc_r     <= acc_nxt;
      subid_r   <= subid_nxt;
      first_r   <= first_nxt;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (fire) begin
        rq_wr_r <= rq_wr_r + RQ_AW'(nres);
      end
      if (pop) begin
        rq_rd_r <= rq_rd_r + RQ_AW'(1);
      end
      rq_cnt_r <= rq_cnt_r + (fire ? (RQ_AW+1)'(nres) : '0) - (RQ_AW+1)'(pop);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (fire && (nres != 2'd0)) begin
      rq_r[rq_wr_r] <= res0;
    end
    if (fire && (nres == 2'd2)) begin
      rq_r[rq_wr_r + RQ_AW'(1)] <= res1;
    end
  end

  // Result channel.
  assign out_tvalid = (rq_cnt_r != '0);
  assign out_tdata  = {4'd0, rq_r[rq_rd_r].err, rq_r[rq_rd_r].value, rq_r[rq_rd_r].tag};
  assign out_tuser  = rq_r[rq_rd_r].kind;
  assign out_tlast  = rq_r[rq_rd_r].eoe;

endmodule
